// ===== hdl/wsfp_pkg.sv =====
// Package for the WebSocket frame parser: status codes, opcode and length
// constants, and the per-byte result type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsfp_pkg;

  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_PENDING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MESSAGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLOSE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PING    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PONG    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd5;

  localparam logic [3:0] OP_DATA_MAX = 4'h2;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;
  localparam logic [3:0] OP_PONG     = 4'hA;
  localparam logic [3:0] OP_NONE     = 4'h0;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // remaining extended-length bytes after the first one
  localparam logic [2:0] EXT16_LEFT = 3'd1;
  localparam logic [2:0] EXT64_LEFT = 3'd7;
  localparam logic [1:0] KEY_LAST   = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                payload_valid;
    logic [7:0]          unmasked_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/wsfp_core.sv =====
// Frame parser state and per-byte step logic; one byte per enabled cycle.
// Depends on wsfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsfp_core #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [7:0]        data_byte,
  input  wire logic              mask_required,
  output wsfp_pkg::result_t      result
);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]             key_r [4];
  logic [7:0]             key_nxt [4];
  logic                   fin_r, fin_nxt;
  logic [3:0]             ctl_r, ctl_nxt;
  logic                   masked_r, masked_nxt;

  logic [wsfp_pkg::STATUS_W-1:0] end_st;
  logic [3:0]                    op;
  logic [6:0]                    len7;
  logic [LENGTH_BITS-1:0]        pos_inc;
  logic [LENGTH_BITS-1:0]        len_shift;

  assign op        = data_byte[3:0];
  assign len7      = data_byte[6:0];
  assign pos_inc   = pos_r + LENGTH_BITS'(1);
  assign len_shift = {len_r[LENGTH_BITS-9:0], data_byte};

  always_comb begin
    if (ctl_r == wsfp_pkg::OP_CLOSE) begin
      end_st = wsfp_pkg::ST_CLOSE;
    end else if (ctl_r == wsfp_pkg::OP_PING) begin
      end_st = wsfp_pkg::ST_PING;
    end else if (ctl_r == wsfp_pkg::OP_PONG) begin
      end_st = wsfp_pkg::ST_PONG;
    end else begin
      end_st = fin_r ? wsfp_pkg::ST_MESSAGE : wsfp_pkg::ST_PENDING;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    fin_nxt    = fin_r;
    ctl_nxt    = ctl_r;
    masked_nxt = masked_r;
    result     = '{status: wsfp_pkg::ST_PENDING, payload_valid: 1'b0, unmasked_byte: 8'h00};

    case (phase_r)
      PH_HEADER: begin
        len_nxt = '0;
        pos_nxt = '0;
        if (op <= wsfp_pkg::OP_DATA_MAX) begin
          fin_nxt   = data_byte[7];
          ctl_nxt   = wsfp_pkg::OP_NONE;
          phase_nxt = PH_LEN;
        end else if (op == wsfp_pkg::OP_CLOSE || op == wsfp_pkg::OP_PING ||
                     op == wsfp_pkg::OP_PONG) begin
          ctl_nxt   = op;
          phase_nxt = PH_LEN;
        end else begin
          ctl_nxt       = wsfp_pkg::OP_NONE;
          result.status = wsfp_pkg::ST_BAD;
        end
      end
      PH_LEN: begin
        masked_nxt = data_byte[7];
        if (data_byte[7] != mask_required) begin
          phase_nxt     = PH_HEADER;
          len_nxt       = '0;
          pos_nxt       = '0;
          ctl_nxt       = wsfp_pkg::OP_NONE;
          result.status = wsfp_pkg::ST_BAD;
        end else if (len7 == wsfp_pkg::LEN_EXT16) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT;
          cnt_nxt   = wsfp_pkg::EXT16_LEFT;
        end else if (len7 == wsfp_pkg::LEN_EXT64) begin
          len_nxt   = '0;
          phase_nxt = PH_EXT;
          cnt_nxt   = wsfp_pkg::EXT64_LEFT;
        end else begin
          len_nxt = LENGTH_BITS'(len7);
          if (data_byte[7]) begin
            phase_nxt = PH_KEY;
            cnt_nxt   = '0;
          end else if (len7 == '0) begin
            phase_nxt     = PH_HEADER;
            pos_nxt       = '0;
            ctl_nxt       = wsfp_pkg::OP_NONE;
            result.status = end_st;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_EXT: begin
        if (len_r[LENGTH_BITS-1 -: 8] != 8'h00) begin
          phase_nxt     = PH_HEADER;
          len_nxt       = '0;
          pos_nxt       = '0;
          ctl_nxt       = wsfp_pkg::OP_NONE;
          result.status = wsfp_pkg::ST_BAD;
        end else begin
          len_nxt = len_shift;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 3'd1;
          end else if (masked_r) begin
            phase_nxt = PH_KEY;
            cnt_nxt   = '0;
          end else if (len_shift == '0) begin
            phase_nxt     = PH_HEADER;
            pos_nxt       = '0;
            ctl_nxt       = wsfp_pkg::OP_NONE;
            result.status = end_st;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        key_nxt[cnt_r[1:0]] = data_byte;
        if (cnt_r[1:0] == wsfp_pkg::KEY_LAST) begin
          if (len_r == '0) begin
            phase_nxt     = PH_HEADER;
            pos_nxt       = '0;
            ctl_nxt       = wsfp_pkg::OP_NONE;
            result.status = end_st;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        if (ctl_r == wsfp_pkg::OP_NONE) begin
          result.payload_valid = 1'b1;
          result.unmasked_byte = masked_r ? (data_byte ^ key_r[pos_r[1:0]]) : data_byte;
        end
        pos_nxt = pos_inc;
        if (pos_inc >= len_r) begin
          phase_nxt     = PH_HEADER;
          pos_nxt       = '0;
          ctl_nxt       = wsfp_pkg::OP_NONE;
          result.status = end_st;
        end
      end
      default: begin
        phase_nxt     = PH_HEADER;
        len_nxt       = '0;
        pos_nxt       = '0;
        ctl_nxt       = wsfp_pkg::OP_NONE;
        result.status = wsfp_pkg::ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      len_r    <= '0;
      pos_r    <= '0;
      key_r    <= '{default: 8'h00};
      fin_r    <= 1'b0;
      ctl_r    <= wsfp_pkg::OP_NONE;
      masked_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      key_r    <= key_nxt;
      fin_r    <= fin_nxt;
      ctl_r    <= ctl_nxt;
      masked_r <= masked_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_parser_top.sv =====
// WebSocket frame parser top level: input register, parser core, result register.
// Depends on wsfp_pkg and wsfp_core.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) takes one received byte
//   of the WebSocket stream per transaction. Result channel (out_valid /
//   out_stall / out_status, out_payload_valid, out_unmasked_byte) returns
//   exactly one result per input byte, in order.
//   cfg_wr_en / cfg_wr_data write the mask-required bit; write only while idle.
//   Path: an accepted byte passes the input register, then the result
//   register, before its result is offered on out_valid. Throughput: one byte
//   per cycle unless out_stall holds a waiting result; the
//   per-byte step is a single pass of header/length/key/payload logic plus a
//   LENGTH_BITS-wide increment and compare on the payload counter.
//   When out_stall is high with a result waiting, the input register holds its
//   byte and in_stall rises only if that register is also full; nothing is
//   dropped.
//   Reset (synchronous, rst_n low): both registers empty, parser at frame
//   header, mask-required bit set to 1.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_parser_top #(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic            out_payload_valid,
  output logic [7:0]      out_unmasked_byte,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);

  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              out_v_r;
  wsfp_pkg::result_t out_res_r;
  logic              mask_req_r;

  logic              advance;
  logic              step_en;
  logic              in_accept;
  wsfp_pkg::result_t step_res;

  assign advance   = !out_v_r || !out_stall;
  assign step_en   = in_v_r && advance;
  assign in_stall  = in_v_r && !advance;
  assign in_accept = in_valid && !in_stall;

  wsfp_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .data_byte    (in_byte_r),
    .mask_required(mask_req_r),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      mask_req_r <= 1'b1;
    end else begin
      if (in_accept) begin
        in_v_r <= 1'b1;
      end else if (step_en) begin
        in_v_r <= 1'b0;
      end
      if (step_en) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        mask_req_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_data_byte;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = out_res_r.status;
  assign out_payload_valid = out_res_r.payload_valid;
  assign out_unmasked_byte = out_res_r.unmasked_byte;

`ifndef NO_ASSERTIONS
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.payload_valid) |->
      (out_res_r.status == wsfp_pkg::ST_PENDING ||
       out_res_r.status == wsfp_pkg::ST_MESSAGE))
    else $error("payload byte reported with a control or bad status");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_res_r.payload_valid) |-> (out_res_r.unmasked_byte == 8'h00))
    else $error("unmasked byte nonzero without payload");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> !in_stall)
    else $error("input stalled while result register empty");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("processed byte did not reach the result register");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for websocket_frame_parser_top: feeds directed and random WebSocket frames
// byte by byte under random idling and checks every result against a built-in frame parser.
// Depends on wsfp_pkg and websocket_frame_parser_top.

module testbench;

  localparam int LEN_BITS    = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 335;

  typedef enum logic [2:0] {AT_HEADER, AT_LENGTH, AT_EXT_LEN, AT_KEY, AT_PAYLOAD} parse_phase_t;
  typedef enum logic [1:0] {LF_SHORT, LF_EXT16, LF_EXT64} len_form_t;
  typedef enum logic [2:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  class frame_scoreboard;
    bit                mask_req = 1'b1;
    parse_phase_t      phase = AT_HEADER;
    logic [63:0]       frame_len = '0;
    logic [63:0]       byte_pos = '0;
    logic [3:0][7:0]   key_bytes = '0;
    bit                fin_bit = 1'b0;
    bit                masked = 1'b0;
    logic [3:0]        ctrl_op = wsfp_pkg::OP_NONE;
    logic [2:0]        ext_left = '0;
    logic [1:0]        key_idx = '0;
    wsfp_pkg::result_t expected_results[$];
    int                fails = 0;

    function logic [2:0] drop_frame();
      phase = AT_HEADER;
      frame_len = '0;
      byte_pos = '0;
      ctrl_op = wsfp_pkg::OP_NONE;
      return wsfp_pkg::ST_BAD;
    endfunction

    function logic [2:0] close_frame();
      logic [2:0] st;
      phase = AT_HEADER;
      byte_pos = '0;
      case (ctrl_op)
        wsfp_pkg::OP_CLOSE: st = wsfp_pkg::ST_CLOSE;
        wsfp_pkg::OP_PING:  st = wsfp_pkg::ST_PING;
        wsfp_pkg::OP_PONG:  st = wsfp_pkg::ST_PONG;
        default:  st = fin_bit ? wsfp_pkg::ST_MESSAGE : wsfp_pkg::ST_PENDING;
      endcase
      ctrl_op = wsfp_pkg::OP_NONE;
      return st;
    endfunction

    function logic [2:0] length_known();
      if (masked) begin
        phase = AT_KEY;
        key_idx = '0;
        return wsfp_pkg::ST_PENDING;
      end
      if (frame_len == 0) return close_frame();
      phase = AT_PAYLOAD;
      return wsfp_pkg::ST_PENDING;
    endfunction

    function wsfp_pkg::result_t parse_byte(logic [7:0] b);
      wsfp_pkg::result_t r;
      r = '0;
      r.status = wsfp_pkg::ST_PENDING;
      case (phase)
        AT_HEADER: begin
          if (b[3:0] <= wsfp_pkg::OP_DATA_MAX) begin
            fin_bit = b[7];
            ctrl_op = wsfp_pkg::OP_NONE;
            phase = AT_LENGTH;
          end else if (b[3:0] >= wsfp_pkg::OP_CLOSE && b[3:0] <= wsfp_pkg::OP_PONG) begin
            ctrl_op = b[3:0];
            phase = AT_LENGTH;
          end else begin
            r.status = drop_frame();
          end
          frame_len = '0;
          byte_pos = '0;
        end
        AT_LENGTH: begin
          masked = b[7];
          if (masked != mask_req) begin
            r.status = drop_frame();
          end else if (b[6:0] == wsfp_pkg::LEN_EXT16) begin
            frame_len = '0;
            ext_left = wsfp_pkg::EXT16_LEFT;
            phase = AT_EXT_LEN;
          end else if (b[6:0] == wsfp_pkg::LEN_EXT64) begin
            frame_len = '0;
            ext_left = wsfp_pkg::EXT64_LEFT;
            phase = AT_EXT_LEN;
          end else begin
            frame_len = 64'(b[6:0]);
            r.status = length_known();
          end
        end
        AT_EXT_LEN: begin
          if ((frame_len >> (LEN_BITS - 8)) != 0) begin
            r.status = drop_frame();
          end else begin
            frame_len = (frame_len << 8) | 64'(b);
            if (ext_left == 0) r.status = length_known();
            else ext_left--;
          end
        end
        AT_KEY: begin
          key_bytes[key_idx] = b;
          if (key_idx == wsfp_pkg::KEY_LAST) begin
            if (frame_len == 0) r.status = close_frame();
            else phase = AT_PAYLOAD;
          end else begin
            key_idx++;
          end
        end
        AT_PAYLOAD: begin
          if (ctrl_op == wsfp_pkg::OP_NONE) begin
            r.payload_valid = 1'b1;
            r.unmasked_byte = masked ? (b ^ key_bytes[byte_pos[1:0]]) : b;
          end
          byte_pos++;
          if (byte_pos >= frame_len) r.status = close_frame();
        end
        default: r.status = drop_frame();
      endcase
      return r;
    endfunction

    function void take_byte(logic [7:0] b);
      expected_results.insert(expected_results.size(), parse_byte(b));
    endfunction

    function void check_result(wsfp_pkg::result_t got);
      wsfp_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status=%0d", got.status);
        fails++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.payload_valid !== want.payload_valid) begin
        $error("payload_valid: expected %0d, got %0d", want.payload_valid, got.payload_valid);
        fails++;
      end
      if (got.unmasked_byte !== want.unmasked_byte) begin
        $error("unmasked_byte: expected 0x%02h, got 0x%02h", want.unmasked_byte,
               got.unmasked_byte);
        fails++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_status;
  logic       out_payload_valid;
  logic [7:0] out_unmasked_byte;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  frame_scoreboard frames;
  bit          mask_now = 1'b1;
  int          burst_left = 0;
  int unsigned bytes_sent = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          mode_left = 0;
  int unsigned rx_tick = 0;
  int          idle_cycles = 0;

  websocket_frame_parser_top #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_payload_valid(out_payload_valid),
    .out_unmasked_byte(out_unmasked_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) frames.take_byte(in_data_byte);
    if (rst_n && out_valid && !out_stall)
      frames.check_result(
        wsfp_pkg::result_t'({out_status, out_payload_valid, out_unmasked_byte}));
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side: random stall modes, plus one long hold-off on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 4));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
        RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
        RX_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        default:  out_stall <= (rx_tick[2:0] < 3);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input bit fin, input bit mbit,
                            input int unsigned len, input len_form_t form);
    logic [7:0]  q[$];
    logic [63:0] l64;
    l64 = 64'(len);
    q.insert(q.size(), {fin, 3'($urandom_range(0, 7)), op});
    case (form)
      LF_SHORT: q.insert(q.size(), {mbit, 7'(len)});
      LF_EXT16: begin
        q.insert(q.size(), {mbit, wsfp_pkg::LEN_EXT16});
        for (int i = 1; i >= 0; i--) q.insert(q.size(), l64[i*8 +: 8]);
      end
      default: begin
        q.insert(q.size(), {mbit, wsfp_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) q.insert(q.size(), l64[i*8 +: 8]);
      end
    endcase
    if (mbit) repeat (4) q.insert(q.size(), 8'($urandom));
    repeat (len) q.insert(q.size(), 8'($urandom));
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic random_frame();
    logic [3:0]  op;
    int unsigned len;
    int          pick;
    len_form_t   form;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      op = 4'($urandom_range(3, 12));
      if (op >= wsfp_pkg::OP_CLOSE) op = op + 4'd3;
      send_byte({4'($urandom), op});
    end else if (pick < 18) begin
      send_byte({4'($urandom), 4'($urandom_range(0, 2))});
      send_byte({~mask_now, 7'($urandom)});
    end else begin
      if ($urandom_range(0, 9) < 7) op = 4'($urandom_range(0, 2));
      else op = 4'($urandom_range(wsfp_pkg::OP_CLOSE, wsfp_pkg::OP_PONG));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        form = LF_SHORT;
        len = 125;
      end else if (pick < 70) begin
        form = LF_SHORT;
        len = $urandom_range(0, 12);
      end else if (pick < 85) begin
        form = LF_EXT16;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 40);
      end else begin
        form = LF_EXT64;
        len = $urandom_range(0, 24);
      end
      send_frame(op, 1'($urandom), mask_now, len, form);
    end
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (frames.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mask(input bit v);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    frames.mask_req = v;
    mask_now = v;
  endtask

  initial begin
    int unsigned phase_start;
    frames = new();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset setting requires masked frames
    send_byte(8'hFF);
    send_byte(8'h8B);
    send_byte(8'h81);
    send_byte(8'h05);
    send_frame(wsfp_pkg::OP_PING, 1'b1, 1'b1, 0, LF_SHORT);
    send_frame(4'h1, 1'b1, 1'b1, 2, LF_SHORT);
    send_frame(wsfp_pkg::OP_CLOSE, 1'b1, 1'b1, 1, LF_SHORT);

    for (int p = 0; p < 4; p++) begin
      set_mask(p[0]);
      if (p == 1) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) random_frame();
    end

    drain();
    if (frames.fails == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wsfp_pkg.sv
hdl/wsfp_core.sv
hdl/websocket_frame_parser_top.sv
sim/testbench.sv
